>>> rtl/ltb_pkg.sv
// Shared types and constants for the line-indexed text buffer.
`timescale 1ns / 1ps
`default_nettype none

package ltb_pkg;

  localparam int unsigned MaxChars = 4096;
  localparam int unsigned MaxLines = 1024;

  localparam logic [20:0] NewlineCp = 21'd10;

  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_APPEND    = 3'd1,
    OP_DELETE    = 3'd2,
    OP_BACKSPACE = 3'd3,
    OP_READ_CP   = 3'd4,
    OP_READ_LINE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RDL,
    S_EXEC,
    S_RD2,
    S_CSHIFT,
    S_LSHIFT,
    S_NLWR1,
    S_NLWR2,
    S_CINS,
    S_CDEL,
    S_JOIN,
    S_RDC,
    S_RDLN,
    S_DONE
  } state_e;

  // Shift engine: UP reads descending and writes one above, DOWN reads
  // ascending and writes one below, INPLACE rewrites the same entry.
  typedef enum logic [1:0] {
    EM_UP,
    EM_DOWN,
    EM_INPLACE
  } eng_mode_e;

  typedef enum logic [1:0] {
    D_NONE,
    D_INC,
    D_DEC
  } delta_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [20:0] codepoint;
    logic [11:0] index;
  } in_t;

  typedef struct packed {
    logic [20:0] read_value;
    logic [12:0] line_start;
    logic [12:0] line_length;
    logic [9:0]  cursor_line;
    logic [12:0] cursor_column;
    logic [10:0] line_count;
    logic [12:0] total_codepoints;
    logic [1:0]  status;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/ltb_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module ltb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/ltb_ctrl.sv
// Edit sequencer: cursor and count registers, shift engine, memory ports.
`timescale 1ns / 1ps
`default_nettype none

module ltb_ctrl
  import ltb_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MaxChars,
  parameter int unsigned MAX_LINES = MaxLines,
  localparam int unsigned AW  = $clog2(MAX_CHARS),
  localparam int unsigned LW  = $clog2(MAX_LINES),
  localparam int unsigned CNW = $clog2(MAX_CHARS + 1),
  localparam int unsigned LCW = $clog2(MAX_LINES + 1),
  localparam int unsigned LDW = 2 * CNW
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire in_t            in_data_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output res_t                res_o,
  output logic                char_we_o,
  output logic [AW-1:0]       char_waddr_o,
  output logic [20:0]         char_wdata_o,
  output logic [AW-1:0]       char_raddr_o,
  input  wire logic [20:0]    char_rdata_i,
  output logic                line_we_o,
  output logic [LW-1:0]       line_waddr_o,
  output logic [LDW-1:0]      line_wdata_o,
  output logic [LW-1:0]       line_raddr_o,
  input  wire logic [LDW-1:0] line_rdata_i
);

  localparam int unsigned EW = (CNW > LCW) ? CNW : LCW;

  state_e state_q, state_d, after_q, after_d;
  eng_mode_e eng_mode_q, eng_mode_d;
  delta_e eng_dlt_q, eng_dlt_d;

  logic [2:0]     op_q, op_d;
  logic [20:0]    cp_q, cp_d;
  logic [11:0]    idx_q, idx_d;
  logic [LCW-1:0] lines_used_q, lines_used_d;
  logic [CNW-1:0] chars_used_q, chars_used_d;
  logic [LW-1:0]  cur_line_q, cur_line_d;
  logic [CNW-1:0] cur_col_q, cur_col_d;
  logic [CNW-1:0] ls_q, ls_d, ll_q, ll_d, pos_q, pos_d;
  logic [20:0]    rv_q, rv_d;
  logic [CNW-1:0] rls_q, rls_d, rll_q, rll_d;
  logic [1:0]     st_q, st_d;
  logic [EW-1:0]  eng_ptr_q, eng_ptr_d, eng_cnt_q, eng_cnt_d, eng_wa_q, eng_wa_d;
  logic           eng_pend_q, eng_pend_d;
  logic           l0_valid_q, rd_zero_q;

  logic [CNW-1:0] lrd_start, lrd_len, col_w, ins_pos, del_col, del_pos, adj_start;
  logic           is_nl, lines_full, chars_full, has_next, at_end, eng_done;
  logic           idx_ok_c, idx_ok_l;
  logic [EW-1:0]  ext_line, ext_lines, ext_chars;

  // Entry 0 of the line table reads as zero until it is first written.
  assign lrd_start = (rd_zero_q && !l0_valid_q) ? '0 : line_rdata_i[LDW-1:CNW];
  assign lrd_len   = (rd_zero_q && !l0_valid_q) ? '0 : line_rdata_i[CNW-1:0];

  assign col_w      = (cur_col_q > ll_q) ? ll_q : cur_col_q;
  assign is_nl      = (cp_q == NewlineCp);
  assign lines_full = (lines_used_q >= LCW'(MAX_LINES));
  assign chars_full = (chars_used_q >= CNW'(MAX_CHARS));
  assign ext_line   = EW'(cur_line_q);
  assign ext_lines  = EW'(lines_used_q);
  assign ext_chars  = EW'(chars_used_q);
  assign has_next   = (ext_line + EW'(1)) < ext_lines;
  assign at_end     = (col_w == ll_q);
  assign eng_done   = (eng_cnt_q == '0) && !eng_pend_q;
  assign idx_ok_c   = 32'(idx_q) < 32'(chars_used_q);
  assign idx_ok_l   = 32'(idx_q) < 32'(lines_used_q);
  assign ins_pos    = ((ls_q + col_w) > chars_used_q) ? chars_used_q : (ls_q + col_w);
  assign del_col    = (op_q == OP_BACKSPACE) ? (col_w - CNW'(1)) : col_w;
  assign del_pos    = ls_q + del_col;

  always_comb begin
    case (eng_dlt_q)
      D_INC:   adj_start = lrd_start + CNW'(1);
      D_DEC:   adj_start = lrd_start - CNW'(1);
      default: adj_start = lrd_start;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.read_value       = rv_q;
    res_o.line_start       = 13'(rls_q);
    res_o.line_length      = 13'(rll_q);
    res_o.cursor_line      = 10'(cur_line_q);
    res_o.cursor_column    = 13'(cur_col_q);
    res_o.line_count       = 11'(lines_used_q);
    res_o.total_codepoints = 13'(chars_used_q);
    res_o.status           = st_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (op_q)
          OP_INSERT, OP_APPEND, OP_DELETE, OP_BACKSPACE: state_d = S_RDL;
          OP_READ_CP:   state_d = idx_ok_c ? S_RDC : S_DONE;
          OP_READ_LINE: state_d = idx_ok_l ? S_RDLN : S_DONE;
          default:      state_d = S_DONE;
        endcase
      end
      S_RDL:    state_d = S_EXEC;
      S_EXEC: begin
        case (op_q)
          OP_INSERT: begin
            if (is_nl) state_d = lines_full ? S_DONE : S_LSHIFT;
            else       state_d = chars_full ? S_DONE : S_CSHIFT;
          end
          OP_DELETE: begin
            if (at_end) state_d = has_next ? S_RD2 : S_DONE;
            else        state_d = S_CSHIFT;
          end
          OP_BACKSPACE: begin
            if (col_w == '0) state_d = (cur_line_q != '0) ? S_RD2 : S_DONE;
            else             state_d = S_CSHIFT;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RD2:    state_d = S_LSHIFT;
      S_CSHIFT: if (eng_done) state_d = after_q;
      S_LSHIFT: if (eng_done) state_d = after_q;
      S_NLWR1:  state_d = S_NLWR2;
      S_NLWR2:  state_d = S_DONE;
      S_CINS:   state_d = S_LSHIFT;
      S_CDEL:   state_d = S_LSHIFT;
      S_JOIN:   state_d = S_DONE;
      S_RDC:    state_d = S_DONE;
      S_RDLN:   state_d = S_DONE;
      S_DONE:   if (res_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and memory ports
  always_comb begin
    op_d = op_q;  cp_d = cp_q;  idx_d = idx_q;
    lines_used_d = lines_used_q;  chars_used_d = chars_used_q;
    cur_line_d = cur_line_q;  cur_col_d = cur_col_q;
    ls_d = ls_q;  ll_d = ll_q;  pos_d = pos_q;
    rv_d = rv_q;  rls_d = rls_q;  rll_d = rll_q;  st_d = st_q;
    eng_ptr_d = eng_ptr_q;  eng_cnt_d = eng_cnt_q;  eng_wa_d = eng_wa_q;
    eng_pend_d = eng_pend_q;  eng_mode_d = eng_mode_q;  eng_dlt_d = eng_dlt_q;
    after_d = after_q;
    char_we_o = 1'b0;  char_waddr_o = '0;  char_wdata_o = cp_q;  char_raddr_o = '0;
    line_we_o = 1'b0;  line_waddr_o = '0;  line_wdata_o = '0;  line_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = in_data_i.opcode;
          cp_d  = in_data_i.codepoint;
          idx_d = in_data_i.index;
          rv_d  = '0;  rls_d = '0;  rll_d = '0;
          st_d  = ST_OK;
        end
      end
      S_DECODE: begin
        case (op_q)
          OP_READ_CP: begin
            if (idx_ok_c) char_raddr_o = AW'(idx_q);
            else          st_d = ST_RANGE;
          end
          OP_READ_LINE: begin
            if (idx_ok_l) line_raddr_o = LW'(idx_q);
            else          st_d = ST_RANGE;
          end
          OP_APPEND: line_raddr_o = LW'(lines_used_q - LCW'(1));
          default:   line_raddr_o = cur_line_q;
        endcase
      end
      S_RDL: begin
        ls_d = lrd_start;
        ll_d = lrd_len;
      end
      S_EXEC: begin
        eng_pend_d = 1'b0;
        eng_dlt_d  = D_NONE;
        case (op_q)
          OP_INSERT: begin
            cur_col_d = col_w;
            if (is_nl) begin
              if (lines_full) begin
                st_d = ST_FULL;
              end else begin
                eng_mode_d = EM_UP;
                eng_ptr_d  = ext_lines - EW'(1);
                eng_cnt_d  = ext_lines - ext_line - EW'(1);
                after_d    = S_NLWR1;
              end
            end else if (chars_full) begin
              st_d = ST_FULL;
            end else begin
              pos_d      = ins_pos;
              eng_mode_d = EM_UP;
              eng_ptr_d  = ext_chars - EW'(1);
              eng_cnt_d  = ext_chars - EW'(ins_pos);
              after_d    = S_CINS;
            end
          end
          OP_APPEND: begin
            if (is_nl) begin
              if (lines_full) begin
                st_d = ST_FULL;
              end else begin
                line_we_o    = 1'b1;
                line_waddr_o = LW'(lines_used_q);
                line_wdata_o = {ls_q + ll_q, CNW'(0)};
                lines_used_d = lines_used_q + LCW'(1);
                cur_line_d   = cur_line_q + LW'(1);
                cur_col_d    = '0;
              end
            end else if (chars_full) begin
              st_d = ST_FULL;
            end else begin
              char_we_o    = 1'b1;
              char_waddr_o = AW'(chars_used_q);
              char_wdata_o = cp_q;
              line_we_o    = 1'b1;
              line_waddr_o = LW'(lines_used_q - LCW'(1));
              line_wdata_o = {ls_q, ll_q + CNW'(1)};
              chars_used_d = chars_used_q + CNW'(1);
              cur_col_d    = cur_col_q + CNW'(1);
            end
          end
          OP_DELETE, OP_BACKSPACE: begin
            cur_col_d = col_w;
            if ((op_q == OP_DELETE) ? at_end : (col_w == '0)) begin
              // line join: fetch the neighbor entry
              if (op_q == OP_DELETE) line_raddr_o = cur_line_q + LW'(1);
              else                   line_raddr_o = cur_line_q - LW'(1);
            end else begin
              cur_col_d  = del_col;
              pos_d      = del_pos;
              eng_mode_d = EM_DOWN;
              eng_ptr_d  = EW'(del_pos) + EW'(1);
              eng_cnt_d  = ext_chars - EW'(del_pos) - EW'(1);
              after_d    = S_CDEL;
            end
          end
          default: ;
        endcase
      end
      S_RD2: begin
        line_we_o  = 1'b1;
        eng_mode_d = EM_DOWN;
        eng_dlt_d  = D_NONE;
        eng_pend_d = 1'b0;
        after_d    = S_JOIN;
        if (op_q == OP_DELETE) begin
          line_waddr_o = cur_line_q;
          line_wdata_o = {ls_q, ll_q + lrd_len};
          eng_ptr_d    = ext_line + EW'(2);
          eng_cnt_d    = ext_lines - ext_line - EW'(2);
        end else begin
          line_waddr_o = cur_line_q - LW'(1);
          line_wdata_o = {lrd_start, lrd_len + ll_q};
          cur_col_d    = lrd_len;
          eng_ptr_d    = ext_line + EW'(1);
          eng_cnt_d    = ext_lines - ext_line - EW'(1);
        end
      end
      S_CSHIFT, S_LSHIFT: begin
        if (state_q == S_CSHIFT) begin
          char_we_o    = eng_pend_q;
          char_waddr_o = AW'(eng_wa_q);
          char_wdata_o = char_rdata_i;
          char_raddr_o = AW'(eng_ptr_q);
        end else begin
          line_we_o    = eng_pend_q;
          line_waddr_o = LW'(eng_wa_q);
          line_wdata_o = {adj_start, lrd_len};
          line_raddr_o = LW'(eng_ptr_q);
        end
        if (eng_cnt_q != '0) begin
          eng_pend_d = 1'b1;
          eng_cnt_d  = eng_cnt_q - EW'(1);
          case (eng_mode_q)
            EM_UP: begin
              eng_wa_d  = eng_ptr_q + EW'(1);
              eng_ptr_d = eng_ptr_q - EW'(1);
            end
            EM_DOWN: begin
              eng_wa_d  = eng_ptr_q - EW'(1);
              eng_ptr_d = eng_ptr_q + EW'(1);
            end
            default: begin
              eng_wa_d  = eng_ptr_q;
              eng_ptr_d = eng_ptr_q + EW'(1);
            end
          endcase
        end else begin
          eng_pend_d = 1'b0;
        end
      end
      S_NLWR1: begin
        line_we_o    = 1'b1;
        line_waddr_o = cur_line_q + LW'(1);
        line_wdata_o = {ls_q + cur_col_q, ll_q - cur_col_q};
      end
      S_NLWR2: begin
        line_we_o    = 1'b1;
        line_waddr_o = cur_line_q;
        line_wdata_o = {ls_q, cur_col_q};
        lines_used_d = lines_used_q + LCW'(1);
        cur_line_d   = cur_line_q + LW'(1);
        cur_col_d    = '0;
      end
      S_CINS, S_CDEL: begin
        line_we_o    = 1'b1;
        line_waddr_o = cur_line_q;
        eng_mode_d   = EM_INPLACE;
        eng_pend_d   = 1'b0;
        eng_ptr_d    = ext_line + EW'(1);
        eng_cnt_d    = ext_lines - ext_line - EW'(1);
        after_d      = S_DONE;
        if (state_q == S_CINS) begin
          char_we_o    = 1'b1;
          char_waddr_o = AW'(pos_q);
          char_wdata_o = cp_q;
          line_wdata_o = {ls_q, ll_q + CNW'(1)};
          chars_used_d = chars_used_q + CNW'(1);
          cur_col_d    = cur_col_q + CNW'(1);
          eng_dlt_d    = D_INC;
        end else begin
          line_wdata_o = {ls_q, ll_q - CNW'(1)};
          chars_used_d = chars_used_q - CNW'(1);
          eng_dlt_d    = D_DEC;
        end
      end
      S_JOIN: begin
        lines_used_d = lines_used_q - LCW'(1);
        if (op_q == OP_BACKSPACE) cur_line_d = cur_line_q - LW'(1);
      end
      S_RDC:  rv_d = char_rdata_i;
      S_RDLN: begin
        rls_d = lrd_start;
        rll_d = lrd_len;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      after_q      <= S_DONE;
      lines_used_q <= LCW'(1);
      chars_used_q <= '0;
      cur_line_q   <= '0;
      cur_col_q    <= '0;
      eng_pend_q   <= 1'b0;
      eng_cnt_q    <= '0;
      l0_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      after_q      <= after_d;
      lines_used_q <= lines_used_d;
      chars_used_q <= chars_used_d;
      cur_line_q   <= cur_line_d;
      cur_col_q    <= cur_col_d;
      eng_pend_q   <= eng_pend_d;
      eng_cnt_q    <= eng_cnt_d;
      if (line_we_o && (line_waddr_o == '0)) l0_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    cp_q       <= cp_d;
    idx_q      <= idx_d;
    ls_q       <= ls_d;
    ll_q       <= ll_d;
    pos_q      <= pos_d;
    rv_q       <= rv_d;
    rls_q      <= rls_d;
    rll_q      <= rll_d;
    st_q       <= st_d;
    eng_ptr_q  <= eng_ptr_d;
    eng_wa_q   <= eng_wa_d;
    eng_mode_q <= eng_mode_d;
    eng_dlt_q  <= eng_dlt_d;
    rd_zero_q  <= (line_raddr_o == '0);
  end

endmodule

`default_nettype wire

>>> rtl/line_indexed_text_buffer_core.sv
// Top level of the line-indexed text buffer: memories, sequencer, output register.
//
// Usage: one edit or query is a transfer on the input channel (in_valid_i,
// in_ready_o, in_data_i); exactly one result per item is a transfer on the
// output channel (out_valid_o, out_ready_i, out_data_o).
// Items are processed one at a time. Insert and delete move codepoints in the
// codepoint memory one per cycle, then line entries in the line memory one
// per cycle; a newline insert or a line join moves line entries only. The
// single read and single write port of each memory set that rate.
// A finished result sits in an output register; the next item is accepted
// while it waits. If the receiver stalls, the sequencer holds the following
// result until the register drains.
// Reset: one line of length zero, no codepoints, cursor at line 0 column 0;
// no clearing pass is needed, items are accepted right after reset.
`timescale 1ns / 1ps
`default_nettype none

module line_indexed_text_buffer_core
  import ltb_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MaxChars,
  parameter int unsigned MAX_LINES = MaxLines
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_data_o
);

  localparam int unsigned AW  = $clog2(MAX_CHARS);
  localparam int unsigned LW  = $clog2(MAX_LINES);
  localparam int unsigned CNW = $clog2(MAX_CHARS + 1);
  localparam int unsigned LDW = 2 * CNW;

  logic           char_we, line_we;
  logic [AW-1:0]  char_waddr, char_raddr;
  logic [20:0]    char_wdata, char_rdata;
  logic [LW-1:0]  line_waddr, line_raddr;
  logic [LDW-1:0] line_wdata, line_rdata;
  logic           res_valid, res_ready;
  res_t           res;
  logic           out_valid_q;
  res_t           out_q;

  ltb_ram #(.Width(21), .Depth(MAX_CHARS)) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (char_we),
    .waddr_i (char_waddr),
    .wdata_i (char_wdata),
    .raddr_i (char_raddr),
    .rdata_o (char_rdata)
  );

  ltb_ram #(.Width(LDW), .Depth(MAX_LINES)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  ltb_ctrl #(.MAX_CHARS(MAX_CHARS), .MAX_LINES(MAX_LINES)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .char_we_o    (char_we),
    .char_waddr_o (char_waddr),
    .char_wdata_o (char_wdata),
    .char_raddr_o (char_raddr),
    .char_rdata_i (char_rdata),
    .line_we_o    (line_we),
    .line_waddr_o (line_waddr),
    .line_wdata_o (line_wdata),
    .line_raddr_o (line_raddr),
    .line_rdata_i (line_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/ltb_checker.sv
// Port-level checks for the text buffer core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ltb_checker
  import ltb_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire res_t out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK) || (out_data_o.status == ST_FULL)
                    || (out_data_o.status == ST_RANGE))
    else $error("bad status code");

  a_cursor_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 11'(out_data_o.cursor_line) < out_data_o.line_count)
    else $error("cursor line beyond last line");

  a_cursor_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.cursor_column <= out_data_o.total_codepoints)
    else $error("cursor column beyond stored codepoints");

endmodule

bind line_indexed_text_buffer_core ltb_checker u_ltb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the line-indexed text buffer core.
`timescale 1ns / 1ps

module tb_top;
  import ltb_pkg::*;

  localparam int NumRandom = 113;

  int mismatches = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Buffer image that predicts each result.
  class edit_scoreboard;
    logic [20:0] chars[MaxChars];
    logic [12:0] starts[MaxLines];
    logic [12:0] lens[MaxLines];
    int unsigned n_lines, n_chars, cl, cc;
    res_t pending[$];

    function new();
      n_lines = 1;
      n_chars = 0;
      cl = 0;
      cc = 0;
      starts[0] = '0;
      lens[0] = '0;
    endfunction

    function void clamp();
      if (cl >= n_lines) cl = n_lines - 1;
      if (cc > lens[cl]) cc = lens[cl];
    endfunction

    function void drop_line(int unsigned ln);
      for (int unsigned i = ln + 1; i < n_lines; i++) begin
        starts[i-1] = starts[i];
        lens[i-1] = lens[i];
      end
      n_lines--;
    endfunction

    function void delete_at_cursor();
      int unsigned p;
      clamp();
      if (cc == lens[cl]) begin
        if (cl + 1 < n_lines) begin
          lens[cl] += lens[cl+1];
          drop_line(cl + 1);
        end
        return;
      end
      p = starts[cl] + cc;
      for (int unsigned i = p + 1; i < n_chars; i++) chars[i-1] = chars[i];
      n_chars--;
      lens[cl]--;
      for (int unsigned i = cl + 1; i < n_lines; i++) starts[i]--;
    endfunction

    function status_e insert_cp(logic [20:0] cp);
      int unsigned p;
      clamp();
      if (cp == NewlineCp) begin
        if (n_lines >= MaxLines) return ST_FULL;
        for (int unsigned i = n_lines; i > cl + 1; i--) begin
          starts[i] = starts[i-1];
          lens[i] = lens[i-1];
        end
        starts[cl+1] = starts[cl] + cc;
        lens[cl+1] = lens[cl] - cc;
        lens[cl] = cc;
        n_lines++;
        cl++;
        cc = 0;
        return ST_OK;
      end
      if (n_chars >= MaxChars) return ST_FULL;
      p = starts[cl] + cc;
      if (p > n_chars) p = n_chars;
      for (int unsigned i = n_chars; i > p; i--) chars[i] = chars[i-1];
      chars[p] = cp;
      n_chars++;
      lens[cl]++;
      cc++;
      for (int unsigned i = cl + 1; i < n_lines; i++) starts[i]++;
      return ST_OK;
    endfunction

    function status_e append_cp(logic [20:0] cp);
      int unsigned last;
      last = n_lines - 1;
      if (cp == NewlineCp) begin
        if (n_lines >= MaxLines) return ST_FULL;
        starts[n_lines] = starts[last] + lens[last];
        lens[n_lines] = '0;
        n_lines++;
        cl++;
        cc = 0;
        return ST_OK;
      end
      if (n_chars >= MaxChars) return ST_FULL;
      chars[n_chars] = cp;
      n_chars++;
      lens[last]++;
      cc++;
      return ST_OK;
    endfunction

    function void note_input(in_t it);
      res_t r;
      r = '0;
      r.status = ST_OK;
      case (it.opcode)
        OP_INSERT: r.status = insert_cp(it.codepoint);
        OP_APPEND: r.status = append_cp(it.codepoint);
        OP_DELETE: delete_at_cursor();
        OP_BACKSPACE: begin
          clamp();
          if (cc == 0) begin
            if (cl != 0) begin
              cc = lens[cl-1];
              lens[cl-1] += lens[cl];
              drop_line(cl);
              cl--;
            end
          end else begin
            cc--;
            delete_at_cursor();
          end
        end
        OP_READ_CP: begin
          if (it.index < n_chars) r.read_value = chars[it.index];
          else r.status = ST_RANGE;
        end
        OP_READ_LINE: begin
          if (it.index < n_lines) begin
            r.line_start = starts[it.index];
            r.line_length = lens[it.index];
          end else begin
            r.status = ST_RANGE;
          end
        end
        default: ;
      endcase
      r.cursor_line = cl[9:0];
      r.cursor_column = cc[12:0];
      r.line_count = n_lines[10:0];
      r.total_codepoints = n_chars[12:0];
      pending.push_back(r);
    endfunction

    task check_result(res_t got);
      res_t exp_r;
      if (pending.size() == 0) begin
        report_mismatch("result with no item outstanding", 0, 0);
        return;
      end
      exp_r = pending.pop_front();
      if (got.read_value !== exp_r.read_value)
        report_mismatch("read_value", got.read_value, exp_r.read_value);
      if (got.line_start !== exp_r.line_start)
        report_mismatch("line_start", got.line_start, exp_r.line_start);
      if (got.line_length !== exp_r.line_length)
        report_mismatch("line_length", got.line_length, exp_r.line_length);
      if (got.cursor_line !== exp_r.cursor_line)
        report_mismatch("cursor_line", got.cursor_line, exp_r.cursor_line);
      if (got.cursor_column !== exp_r.cursor_column)
        report_mismatch("cursor_column", got.cursor_column, exp_r.cursor_column);
      if (got.line_count !== exp_r.line_count)
        report_mismatch("line_count", got.line_count, exp_r.line_count);
      if (got.total_codepoints !== exp_r.total_codepoints)
        report_mismatch("total_codepoints", got.total_codepoints,
                        exp_r.total_codepoints);
      if (got.status !== exp_r.status)
        report_mismatch("status", got.status, exp_r.status);
    endtask
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_t in_data_i;
  res_t out_data_o;

  edit_scoreboard sb;
  bit quiet_phase = 0;     // no idling on either side
  int hold_cycles = 0;     // long receiver hold-off

  line_indexed_text_buffer_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  function automatic bit idle_now();
    return !quiet_phase && ($urandom_range(99) < 11);
  endfunction

  // Offers one item and holds it until the transfer.
  task automatic send_item(op_e op, logic [20:0] cp, logic [11:0] idx);
    while (idle_now()) @(negedge clk_i);
    in_data_i.opcode = op;
    in_data_i.codepoint = cp;
    in_data_i.index = idx;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(in_data_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_raw(logic [2:0] op, logic [20:0] cp, logic [11:0] idx);
    send_item(op_e'(op), cp, idx);
  endtask

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= !idle_now();
    end
  end

  function automatic logic [20:0] rand_cp();
    case ($urandom_range(9))
      0, 1: return NewlineCp;
      2: return 21'h1FFFFF;
      3: return 21'd0;
      default: return 21'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned k;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-buffer corners, both newline paths, joins, reads.
    send_item(OP_DELETE, 0, 0);
    send_item(OP_BACKSPACE, 0, 0);
    send_item(OP_READ_CP, 0, 0);
    send_item(OP_READ_LINE, 0, 0);
    send_item(OP_READ_LINE, 0, 12'hFFF);
    send_item(OP_APPEND, 21'h1FFFFF, 0);
    send_item(OP_APPEND, 21'd0, 0);
    send_item(OP_APPEND, NewlineCp, 0);
    send_item(OP_APPEND, 21'h10FFFF, 0);
    send_item(OP_INSERT, 21'h41, 0);
    send_item(OP_INSERT, NewlineCp, 0);
    send_item(OP_INSERT, 21'h15555, 0);
    send_item(OP_BACKSPACE, 0, 0);
    send_item(OP_BACKSPACE, 0, 0);
    send_item(OP_READ_CP, 0, 12'd1);
    send_item(OP_READ_CP, 0, 12'hFFF);
    send_item(OP_READ_LINE, 0, 12'd1);
    send_item(OP_DELETE, 0, 0);
    send_raw(3'd6, 21'h0AAAA, 12'hAAA);
    send_raw(3'd7, 21'h15555, 12'h555);
    send_item(OP_READ_LINE, 0, 12'd0);

    // Receiver holds off while items keep coming, so the block stalls its input.
    fork
      hold_cycles = 300;
      for (int i = 0; i < 6; i++) send_item(OP_APPEND, rand_cp(), 0);
    join

    // Random mix, weighted toward edits that grow the buffer, with a quiet stretch.
    for (k = 0; k < NumRandom; k++) begin
      quiet_phase = (k >= 40 && k < 70);
      case ($urandom_range(9))
        0, 1: send_item(OP_INSERT, rand_cp(), 12'($urandom));
        2, 3: send_item(OP_APPEND, rand_cp(), 12'($urandom));
        4: send_item(OP_DELETE, 21'($urandom), 12'($urandom));
        5: send_item(OP_BACKSPACE, 21'($urandom), 12'($urandom));
        6: send_item(OP_READ_CP, 21'($urandom),
                     ($urandom_range(3) == 0) ? 12'($urandom)
                                              : 12'($urandom_range(sb.n_chars)));
        7: send_item(OP_READ_LINE, 21'($urandom),
                     ($urandom_range(3) == 0) ? 12'($urandom)
                                              : 12'($urandom_range(sb.n_lines)));
        default: send_raw(3'($urandom_range(7)), 21'($urandom), 12'($urandom));
      endcase
    end
    quiet_phase = 0;

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/ltb_pkg.sv
rtl/ltb_ram.sv
rtl/ltb_ctrl.sv
rtl/line_indexed_text_buffer_core.sv
rtl/ltb_checker.sv
tb/sv/tb_top.sv
